// ----- hdl/pnls_pkg.sv -----
// Shared constants, types and helpers for the packed-normal shading core.
`timescale 1ns / 1ps
package pnls_pkg;

	// Fraction bits of the internal fixed-point format
	localparam int FRAC_BITS = 15;

	// Q1.15 to FRAC_BITS fractional bits
	localparam int SH_UP = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
	localparam int SH_DN = (FRAC_BITS >= 15) ? 0 : 15 - FRAC_BITS;

	localparam int NW   = FRAC_BITS + 1;      // normal / sun component, signed
	localparam int SQW  = 2 * FRAC_BITS + 1;  // square of a component, unsigned
	localparam int QW   = 2 * FRAC_BITS + 2;  // one minus squares, signed
	localparam int PW   = 2 * FRAC_BITS + 2;  // one product of the dot, signed
	localparam int ZW   = FRAC_BITS + 2;      // decoded nz, signed
	localparam int DW   = 2 * FRAC_BITS + 4;  // dot plus one, signed
	localparam int FW   = FRAC_BITS + 3;      // lighting factor, signed
	localparam int CW   = FRAC_BITS + 10;     // channel times factor, unsigned
	localparam int RGBW = 24;

	localparam longint ONE2 = longint'(1) << (2 * FRAC_BITS);
	localparam longint THR  = ONE2 / 1000;

	localparam logic signed [QW-1:0] ONE2_Q = QW'(ONE2);
	localparam logic signed [QW-1:0] THR_Q  = QW'(THR);
	localparam logic signed [DW-1:0] ONE2_D = DW'(ONE2);

	// Square root: one result bit per iteration, two iterations per stage
	localparam int SQ_ITERS = FRAC_BITS + 1;
	localparam int SQ_PER   = 2;
	localparam int SQ_STG   = (SQ_ITERS + SQ_PER - 1) / SQ_PER;

	typedef enum logic [1:0] {
		REG_SUN_X     = 2'd0,
		REG_SUN_Y     = 2'd1,
		REG_SUN_Z     = 2'd2,
		REG_HIGHLIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SQW-1:0] rem;
		logic [SQW:0]   res;
	} sq_t;

	// Sideband that rides alongside the square root
	typedef struct packed {
		logic [RGBW-1:0]     rgb;
		logic                zero;
		logic                neg;
		logic                sel;
		logic signed [ZW-1:0] raw;
		logic signed [PW:0]   dxy;
	} side_t;

	function automatic logic signed [NW-1:0] to_frac(input logic [15:0] v);
		logic signed [15+SH_UP:0] w;
		w = (16 + SH_UP)'($signed(v));
		w = w <<< SH_UP;
		w = w >>> SH_DN;
		return NW'(w);
	endfunction

	// One restoring step; k picks the trial bit 2^(2F-2k)
	function automatic sq_t sq_step(input sq_t a, input int k);
		logic [SQW:0] bitv;
		logic [SQW:0] trial;
		sq_t          r;
		bitv  = (SQW + 1)'(1) << (2 * (FRAC_BITS - k));
		trial = a.res + bitv;
		r     = a;
		if ({1'b0, a.rem} >= trial) begin
			r.rem = a.rem - trial[SQW-1:0];
			r.res = (a.res >> 1) + bitv;
		end else begin
			r.res = a.res >> 1;
		end
		return r;
	endfunction

endpackage

// ----- hdl/packed_normal_lambert_shade_core.sv -----
// Packed-normal half-Lambert shading core, one voxel word per cycle unless stalled.
`timescale 1ns / 1ps
// Usage
//   Input channel in_valid/in_ready carries a 64-bit node_word: bits 63:32 an
//   encoded normal (nx, ny Q1.15, bit 32 the sign of nz), bits 23:0 RGB.
//   Output channel out_valid/out_ready carries the 25-bit pixel: shaded RGB
//   and the highlight flag in bit 24. A zero normal passes RGB unchanged.
//   Config port: cfg_wr_en, cfg_index (sun_x, sun_y, sun_z, highlight) and
//   cfg_data; write only while no word is in flight.
// Timing
//   An accepted word passes stage 1, stage 2, the SQ_STG root stages and
//   stages 4 to 7 to out_valid; the square root sets the depth. One word may
//   enter every cycle unless stalled; one root bit per iteration, two per stage.
// Reset
//   arst_n clears all valid bits and loads sun = (0, 0, 32767), highlight 0.
// Stall
//   The whole pipe advances when the output register is empty or taken;
//   while out_ready is low with a word waiting, in_ready drops and every
//   stage holds its word.
module packed_normal_lambert_shade_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] node_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [24:0] pixel
);

	localparam int F  = pnls_pkg::FRAC_BITS;
	localparam int NS = pnls_pkg::SQ_STG;

	logic [15:0] sun_x_q, sun_y_q, sun_z_q;
	logic        highlight_q;

	logic adv;

	// stage 1: decode and multiply
	logic signed [pnls_pkg::NW-1:0]   nx_w, ny_w, sx_w, sy_w, sz_w;
	logic signed [2*pnls_pkg::NW-1:0] sqx_w, sqy_w, px_w, py_w;
	logic                             vld_s1;
	logic [pnls_pkg::SQW-1:0]         sqx_s1, sqy_s1;
	logic signed [pnls_pkg::PW-1:0]   px_s1, py_s1;
	logic [pnls_pkg::RGBW-1:0]        rgb_s1;
	logic                             zero_s1, neg_s1;

	// stage 2: one minus squares
	logic signed [pnls_pkg::QW-1:0] q_w;
	logic                           vld_s2;
	pnls_pkg::sq_t                  sq_s2;
	pnls_pkg::side_t                side_s2;

	// stage 3 group: square root, index 0 is the first root stage
	logic            vld_s3 [NS];
	pnls_pkg::sq_t   sq_s3  [NS];
	pnls_pkg::side_t side_s3 [NS];
	pnls_pkg::sq_t   sq_nxt [NS];

	// stage 4: nz and its product
	logic signed [pnls_pkg::ZW-1:0]             nz_mag_w, nz_w;
	logic signed [pnls_pkg::NW+pnls_pkg::ZW-1:0] pz_w;
	logic                                       vld_s4;
	logic signed [pnls_pkg::PW-1:0]             pz_s4;
	pnls_pkg::side_t                            side_s4;

	// stage 5: lighting factor
	logic signed [pnls_pkg::DW-1:0] d_w;
	logic                           vld_s5;
	logic signed [pnls_pkg::FW-1:0] factor_s5;
	logic [pnls_pkg::RGBW-1:0]      rgb_s5;
	logic                           zero_s5;

	// stage 6: channel products
	logic [F+1:0]              fpos_w;
	logic [pnls_pkg::CW-1:0]   pr_w [3];
	logic                      vld_s6;
	logic [pnls_pkg::CW-1:0]   pr_s6 [3];
	logic                      pos_s6;
	logic [pnls_pkg::RGBW-1:0] rgb_s6;
	logic                      zero_s6;

	// stage 7: output register
	logic [pnls_pkg::RGBW-1:0] shade_w;
	logic [9:0]                ch_w [3];
	logic                      vld_s7;
	logic [24:0]               pixel_s7;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sun_x_q     <= 16'd0;
			sun_y_q     <= 16'd0;
			sun_z_q     <= 16'd32767;
			highlight_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (pnls_pkg::cfg_reg_t'(cfg_index))
				pnls_pkg::REG_SUN_X:     sun_x_q     <= cfg_data;
				pnls_pkg::REG_SUN_Y:     sun_y_q     <= cfg_data;
				pnls_pkg::REG_SUN_Z:     sun_z_q     <= cfg_data;
				pnls_pkg::REG_HIGHLIGHT: highlight_q <= cfg_data[0];
			endcase
		end
	end

	assign adv      = !vld_s7 || out_ready;
	assign in_ready = adv;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int j = 0; j < NS; j++) vld_s3[j] <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3[0] <= vld_s2;
			for (int j = 1; j < NS; j++) vld_s3[j] <= vld_s3[j-1];
			vld_s4 <= vld_s3[NS-1];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Stage 1
	always_comb begin
		nx_w  = pnls_pkg::to_frac(node_word[63:48]);
		ny_w  = pnls_pkg::to_frac({node_word[47:33], 1'b0});
		sx_w  = pnls_pkg::to_frac(sun_x_q);
		sy_w  = pnls_pkg::to_frac(sun_y_q);
		sqx_w = nx_w * nx_w;
		sqy_w = ny_w * ny_w;
		px_w  = sx_w * nx_w;
		py_w  = sy_w * ny_w;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1  <= sqx_w[pnls_pkg::SQW-1:0];
			sqy_s1  <= sqy_w[pnls_pkg::SQW-1:0];
			px_s1   <= px_w[pnls_pkg::PW-1:0];
			py_s1   <= py_w[pnls_pkg::PW-1:0];
			rgb_s1  <= node_word[23:0];
			zero_s1 <= (node_word[63:32] == 32'd0);
			neg_s1  <= node_word[32];
		end
	end

	// Stage 2
	assign q_w = pnls_pkg::ONE2_Q - $signed({1'b0, sqx_s1}) - $signed({1'b0, sqy_s1});

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.rgb  <= rgb_s1;
			side_s2.zero <= zero_s1;
			side_s2.neg  <= neg_s1;
			side_s2.sel  <= q_w > pnls_pkg::THR_Q;
			side_s2.raw  <= pnls_pkg::ZW'(q_w >>> F);
			side_s2.dxy  <= (pnls_pkg::PW + 1)'(px_s1) + (pnls_pkg::PW + 1)'(py_s1);
			sq_s2.rem    <= (q_w > pnls_pkg::THR_Q) ? q_w[pnls_pkg::SQW-1:0] : '0;
			sq_s2.res    <= '0;
		end
	end

	// Stage 3 group: restoring square root
	always_comb begin
		for (int j = 0; j < NS; j++) begin
			if (j == 0) sq_nxt[j] = sq_s2;
			else        sq_nxt[j] = sq_s3[j-1];
			for (int i = 0; i < pnls_pkg::SQ_PER; i++) begin
				if (j * pnls_pkg::SQ_PER + i < pnls_pkg::SQ_ITERS) begin
					sq_nxt[j] = pnls_pkg::sq_step(sq_nxt[j], j * pnls_pkg::SQ_PER + i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3[0] <= side_s2;
			for (int j = 1; j < NS; j++) side_s3[j] <= side_s3[j-1];
			for (int j = 0; j < NS; j++) sq_s3[j] <= sq_nxt[j];
		end
	end

	// Stage 4: pick root or raw value, apply sign, multiply by sun z
	always_comb begin
		sz_w     = pnls_pkg::to_frac(sun_z_q);
		nz_mag_w = side_s3[NS-1].sel ? $signed(pnls_pkg::ZW'(sq_s3[NS-1].res))
		                             : side_s3[NS-1].raw;
		nz_w     = side_s3[NS-1].neg ? -nz_mag_w : nz_mag_w;
		pz_w     = sz_w * nz_w;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pz_s4   <= pz_w[pnls_pkg::PW-1:0];
			side_s4 <= side_s3[NS-1];
		end
	end

	// Stage 5: half-Lambert factor, floor((d + 1) / 2)
	assign d_w = pnls_pkg::DW'(side_s4.dxy) + pnls_pkg::DW'(pz_s4) + pnls_pkg::ONE2_D;

	always_ff @(posedge clk) begin
		if (adv) begin
			factor_s5 <= pnls_pkg::FW'(d_w >>> (F + 1));
			rgb_s5    <= side_s4.rgb;
			zero_s5   <= side_s4.zero;
		end
	end

	// Stage 6
	always_comb begin
		fpos_w = factor_s5[F+1:0];
		for (int c = 0; c < 3; c++) begin
			pr_w[c] = pnls_pkg::CW'(rgb_s5[8*c +: 8]) * pnls_pkg::CW'(fpos_w);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) pr_s6[c] <= pr_w[c];
			pos_s6  <= factor_s5 > 0;
			rgb_s6  <= rgb_s5;
			zero_s6 <= zero_s5;
		end
	end

	// Stage 7: saturate and pack
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ch_w[c] = pr_s6[c][F +: 10];
			if (!pos_s6)             shade_w[8*c +: 8] = 8'd0;
			else if (|ch_w[c][9:8]) shade_w[8*c +: 8] = 8'd255;
			else                     shade_w[8*c +: 8] = ch_w[c][7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_s7 <= {highlight_q, zero_s6 ? rgb_s6 : shade_w};
		end
	end

	assign out_valid = vld_s7;
	assign pixel     = pixel_s7;

	// Checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted word did not enter stage 1");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_root_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3[NS-1] && side_s3[NS-1].sel |->
		sq_s3[NS-1].res <= ((pnls_pkg::SQW + 1)'(1) << F))
		else $error("square root above one");

	a_zero_normal_pass: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && adv && zero_s6 |=> pixel[23:0] == $past(rgb_s6))
		else $error("zero normal colour not passed through");

	a_dark_factor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && adv && !zero_s6 && !pos_s6 |=> pixel[23:0] == 24'd0)
		else $error("non-positive factor gave a lit colour");

endmodule
